>>> rtl/prfp_pkg.sv
// Package for the PCM ring frame packer: state and status codes, register
// indexes, field widths and the quarter-wave sine table.
// No dependencies.
`timescale 1ns / 1ps

package prfp_pkg;

	// Field widths fixed by the stream and register formats
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned DEST_W     = 16;
	localparam int unsigned RATE_W     = 16;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned FILL_W     = 10;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 48;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SMP_RATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC = 2'd2;

	// Register reset values
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd49716;

	// Input action codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_PACK = 1'b1;

	// Frame sizing: rate*32/44100 ~= (rate*RATE_RECIP) >> RATE_SHIFT, low by at most one
	localparam logic [RATE_W-1:0] RATE_DIV   = 16'd44100;
	localparam logic [11:0]       RATE_RECIP = 12'd3043;
	localparam int unsigned       RATE_SHIFT = 22;

	// Test tone
	localparam logic [WORD_W-1:0] TONE_STEP  = 32'd42852277;
	localparam logic [RATE_W-1:0] TONE_RATE  = 16'd44100;
	localparam logic [CNT_W-1:0]  TONE_PAIRS = 6'd32;

	typedef enum logic [STATUS_W-1:0] {
		STAT_PUSH_OK   = 3'd0,
		STAT_PUSH_FULL = 3'd1,
		STAT_FRAME     = 3'd2,
		STAT_EMPTY     = 3'd3,
		STAT_TOO_SMALL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT,
		ST_DECIDE,
		ST_HDR,
		ST_BODY
	} state_t;

	localparam logic [15:0] QUARTER_SINE [64] = '{
		16'd0,     16'd499,   16'd997,   16'd1495,  16'd1991,  16'd2487,  16'd2981,  16'd3473,
		16'd3963,  16'd4450,  16'd4935,  16'd5417,  16'd5895,  16'd6370,  16'd6840,  16'd7307,
		16'd7769,  16'd8226,  16'd8678,  16'd9124,  16'd9565,  16'd10000, 16'd10429, 16'd10851,
		16'd11266, 16'd11675, 16'd12076, 16'd12470, 16'd12856, 16'd13234, 16'd13603, 16'd13965,
		16'd14317, 16'd14661, 16'd14996, 16'd15321, 16'd15637, 16'd15943, 16'd16239, 16'd16525,
		16'd16801, 16'd17066, 16'd17321, 16'd17564, 16'd17797, 16'd18019, 16'd18230, 16'd18430,
		16'd18617, 16'd18794, 16'd18959, 16'd19111, 16'd19252, 16'd19382, 16'd19499, 16'd19603,
		16'd19696, 16'd19777, 16'd19845, 16'd19901, 16'd19944, 16'd19975, 16'd19994, 16'd20000
	};

	// Two's complement sine sample for an 8-bit phase
	function automatic logic [15:0] sine_sample(input logic [7:0] phase);
		logic [5:0]  idx;
		logic [15:0] mag;
		idx = phase[6] ? (6'd63 - phase[5:0]) : phase[5:0];
		mag = QUARTER_SINE[idx];
		return phase[7] ? (16'd0 - mag) : mag;
	endfunction

endpackage

>>> rtl/pcm_ring_frame_packer.sv
// PCM ring frame packer top level: stereo sample ring in a synchronous RAM,
// frame sequencer and test-tone generator.
// Depends on prfp_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata {dest, right, left}, tuser action
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata {fill, word}, tuser status, tlast
// cfg       in   cfg_wr_en (no wait)            cfg_index, cfg_wdata
//
// A push or a refusal (empty ring, short destination) loads its result from the decide state,
// then the sequencer returns to idle to take the next transaction. A frame loads the magic
// word from the decide state, then one word per cycle unless the output stalls: header,
// then count sample words from the ring RAM through a one-word prefetch, or tone words.
// Input is taken only in the idle state; a waiting result does not block it.
// Output stalls hold the sequencer and the RAM prefetch. Reset needs no clearing pass.
module pcm_ring_frame_packer #(
	parameter int unsigned RING_DEPTH    = 1024,
	parameter int unsigned FRAME_SAMPLES = 62
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [15:0] left_sample, [31:16] right_sample, [47:32] dest_bytes
	input  logic [prfp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [0] action
	input  logic                               s_axis_tuser,
	// master stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] word, [41:32] fill_level, [47:42] zero
	output logic [prfp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// [2:0] status
	output logic [prfp_pkg::STATUS_W-1:0]      m_axis_tuser,
	output logic                               m_axis_tlast,
	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [prfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prfp_pkg::WORD_W-1:0]        cfg_wdata
);
	import prfp_pkg::*;

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] FRAME_MAX = CNT_W'(FRAME_SAMPLES);

	// configuration registers
	logic [RATE_W-1:0]  smp_rate_q;
	logic               tone_enable_q;
	logic [WORD_W-1:0]  frame_magic_q;

	// ring state
	logic [WORD_W-1:0]  ring_mem [RING_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W-1:0]   fill_q;
	logic [WORD_W-1:0]  rd_data_q;
	logic               pv_q;
	logic [CNT_W-1:0]   rd_left_q;
	logic [WORD_W-1:0]  tone_phase_q;

	// frame sizing pipeline
	logic [27:0]        est_prod;
	logic [CNT_W-1:0]   est_q;
	logic [22:0]        chk_prod;
	logic [22:0]        rate_x32;
	logic [CNT_W:0]     tgt_raw;
	logic [CNT_W-1:0]   target_q;

	// item and sequencer
	state_t             state_q;
	state_t             state_d;
	logic               act_q;
	logic [WORD_W-1:0]  push_word_q;
	logic [DEST_W-1:0]  dest_q;
	logic [CNT_W-1:0]   frame_cnt_q;
	logic [WORD_W-1:0]  hdr_word_q;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [WORD_W-1:0]   out_word_q;
	logic                out_last_q;
	logic [FILL_W-1:0]   out_fill_q;

	// decision terms
	logic               slot_free;
	logic               ring_full;
	logic               ring_empty;
	logic               fill_lt_tgt;
	logic [CNT_W-1:0]   count_ring;
	logic [CNT_W-1:0]   count_sel;
	logic [8:0]         need_bytes;
	logic               too_small;
	logic [PTR_W-1:0]   fill_after;
	logic [15:0]        tone_sample;

	// control from the output decode
	logic               emit;
	status_t            emit_status;
	logic [WORD_W-1:0]  emit_word;
	logic               emit_last;
	logic [PTR_W-1:0]   emit_fill;
	logic [31:0]        emit_fill_wide;
	logic               mem_we;
	logic               decide_frame;
	logic               body_emit;
	logic               rd_issue;

	// Hold configuration registers; a tone_enable write also clears the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_rate_q    <= RATE_RESET;
			tone_enable_q <= 1'b0;
			frame_magic_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SMP_RATE:    smp_rate_q    <= cfg_wdata[RATE_W-1:0];
				REG_TONE_ENABLE: tone_enable_q <= cfg_wdata[0];
				REG_FRAME_MAGIC: frame_magic_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Frame target: estimate by reciprocal multiply, then correct upward once and clamp to 1..FRAME_MAX
	assign est_prod = 28'(smp_rate_q) * 28'(RATE_RECIP);
	assign chk_prod = 23'({1'b0, est_q} + 7'd1) * 23'(RATE_DIV);
	assign rate_x32 = 23'({smp_rate_q, 5'b0});
	assign tgt_raw  = {1'b0, est_q} + ((chk_prod <= rate_x32) ? 7'd1 : 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q    <= '0;
			target_q <= 6'd1;
		end else begin
			est_q <= est_prod[RATE_SHIFT +: CNT_W];
			if (tgt_raw == '0)
				target_q <= 6'd1;
			else if (tgt_raw > {1'b0, FRAME_MAX})
				target_q <= FRAME_MAX;
			else
				target_q <= tgt_raw[CNT_W-1:0];
		end
	end

	// Decision terms for the current item
	assign slot_free   = !out_valid_q || m_axis_tready;
	assign ring_full   = (fill_q == PTR_LAST);
	assign ring_empty  = !tone_enable_q && (fill_q == '0);
	assign fill_lt_tgt = (17'(fill_q) < 17'(target_q));
	assign count_ring  = fill_lt_tgt ? CNT_W'(fill_q) : target_q;
	assign count_sel   = tone_enable_q ? TONE_PAIRS : count_ring;
	assign need_bytes  = 9'd8 + {1'b0, count_sel, 2'b00};
	assign too_small   = (dest_q < 16'(need_bytes));
	assign fill_after  = tone_enable_q ? fill_q : (fill_q - PTR_W'(count_ring));
	assign tone_sample = sine_sample(tone_phase_q[31:24]);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_WAIT;
			ST_WAIT:   state_d = ST_DECIDE;
			ST_DECIDE: if (slot_free) state_d = decide_frame ? ST_HDR : ST_IDLE;
			ST_HDR:    if (slot_free) state_d = ST_BODY;
			ST_BODY:   if (body_emit && frame_cnt_q == 6'd1) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Output decode: which result to load and which side effects to take
	always_comb begin
		emit         = 1'b0;
		emit_status  = STAT_FRAME;
		emit_word    = '0;
		emit_last    = 1'b0;
		emit_fill    = fill_q;
		mem_we       = 1'b0;
		decide_frame = 1'b0;
		body_emit    = 1'b0;
		case (state_q)
			ST_DECIDE: begin
				if (slot_free) begin
					emit = 1'b1;
					if (act_q == ACT_PUSH) begin
						emit_last = 1'b1;
						if (ring_full) begin
							emit_status = STAT_PUSH_FULL;
						end else begin
							emit_status = STAT_PUSH_OK;
							mem_we      = 1'b1;
							emit_fill   = fill_q + PTR_W'(1);
						end
					end else if (ring_empty) begin
						emit_status = STAT_EMPTY;
						emit_last   = 1'b1;
					end else if (too_small) begin
						emit_status = STAT_TOO_SMALL;
						emit_last   = 1'b1;
					end else begin
						emit_word    = frame_magic_q;
						emit_fill    = fill_after;
						decide_frame = 1'b1;
					end
				end
			end
			ST_HDR: begin
				emit      = slot_free;
				emit_word = hdr_word_q;
			end
			ST_BODY: begin
				body_emit = slot_free && (tone_enable_q || pv_q);
				emit      = body_emit;
				emit_word = tone_enable_q ? {tone_sample, tone_sample} : rd_data_q;
				emit_last = (frame_cnt_q == 6'd1);
			end
			default: ;
		endcase
	end

	// Fetch the next ring word when the prefetch slot is empty or being drained
	assign rd_issue = (state_q == ST_HDR || state_q == ST_BODY) && !tone_enable_q &&
		(rd_left_q != '0) && (!pv_q || body_emit);

	assign s_axis_tready = (state_q == ST_IDLE);

	// Sequencer and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (decide_frame)
				frame_cnt_q <= count_sel;
			else if (body_emit)
				frame_cnt_q <= frame_cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_q       <= s_axis_tuser;
			push_word_q <= s_axis_tdata[31:0];
			dest_q      <= s_axis_tdata[47:32];
		end
		if (decide_frame)
			hdr_word_q <= {tone_enable_q ? TONE_RATE : smp_rate_q, 10'b0, count_sel};
	end

	// Ring pointers, fill count and prefetch flag. Writes happen only in the
	// decide state and reads only in the header and body states, so no entry
	// is read and written in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			fill_q    <= '0;
			pv_q      <= 1'b0;
			rd_left_q <= '0;
		end else begin
			if (mem_we) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
				fill_q   <= fill_q + PTR_W'(1);
			end else if (decide_frame) begin
				fill_q <= fill_after;
			end
			if (decide_frame)
				rd_left_q <= tone_enable_q ? '0 : count_ring;
			else if (rd_issue)
				rd_left_q <= rd_left_q - 6'd1;
			if (rd_issue)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (rd_issue)
				pv_q <= 1'b1;
			else if (body_emit)
				pv_q <= 1'b0;
		end
	end

	// Ring RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem[wr_ptr_q] <= push_word_q;
		if (rd_issue)
			rd_data_q <= ring_mem[rd_ptr_q];
	end

	// Advance the tone phase per emitted tone word; clear on tone_enable write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tone_phase_q <= '0;
		else if (cfg_wr_en && cfg_index == REG_TONE_ENABLE)
			tone_phase_q <= '0;
		else if (body_emit && tone_enable_q)
			tone_phase_q <= tone_phase_q + TONE_STEP;
	end

	// Output register: load a result, drop it once taken
	assign emit_fill_wide = 32'(emit_fill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= emit_status;
			out_word_q   <= emit_word;
			out_last_q   <= emit_last;
			out_fill_q   <= emit_fill_wide[FILL_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_fill_q, out_word_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	// A new prefetch into an occupied slot must coincide with draining it
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd_issue && pv_q) |-> body_emit)
		else $error("ring prefetch overwrote an unsent word");

	// The final result of an item returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after last result");

	// Ring words are never fetched past the frame count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BODY && !tone_enable_q) |-> (rd_left_q <= frame_cnt_q))
		else $error("ring reads exceed remaining frame words");

	// Idle means no frame is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!pv_q && rd_left_q == '0))
		else $error("frame state left over in idle");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for pcm_ring_frame_packer: queued stream driver, clocked
// monitor with its own ring/tone predictor, random idling and a long output stall.
// Depends on prfp_pkg and the pcm_ring_frame_packer RTL.
`timescale 1ns / 1ps

module tb;
	import prfp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned MAX_PAIRS = 62;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned SHOWN_MAX = 10;

	// One input operation and one result word as the block sees them
	typedef struct packed {
		logic              act;
		logic [DEST_W-1:0] dest;
		logic [15:0]       right;
		logic [15:0]       left;
	} ring_op_t;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] word;
		logic              last;
		logic [FILL_W-1:0] fill;
	} packer_out_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;
	logic                      s_axis_tuser = ACT_PUSH;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]    m_axis_tdata;
	logic [STATUS_W-1:0]       m_axis_tuser;
	logic                      m_axis_tlast;
	logic                      cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [WORD_W-1:0]         cfg_wdata = '0;

	// Stimulus and expectation stores
	ring_op_t    queued_ops [$];
	packer_out_t owed_words [$];
	ring_op_t    next_op;
	ring_op_t    seen_op;
	packer_out_t head_res;
	logic        s_took = 1'b0;
	logic        hold_off = 1'b0;
	int          send_idle_pct = 29;
	int          recv_idle_pct = 74;
	event        long_hold_go;

	// Shadow of the block state and registers
	logic [WORD_W-1:0] ring_mem [1024];
	logic [FILL_W-1:0] wr_ptr = '0;
	logic [FILL_W-1:0] rd_ptr = '0;
	logic [WORD_W-1:0] phase_acc = '0;
	logic [RATE_W-1:0] cfg_rate = RATE_RESET;
	logic              cfg_tone = 1'b0;
	logic [WORD_W-1:0] cfg_magic = '0;

	int unsigned errors = 0;
	int unsigned n_in = 0;
	int unsigned n_out = 0;
	int unsigned n_frames = 0;
	int unsigned seen_status [8];

	pcm_ring_frame_packer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Sine value for the top phase byte, mirrored from the quarter-wave table
	function automatic logic [15:0] tone_value(input logic [7:0] ph);
		logic [15:0] mag;
		case (ph[7:6])
			2'd0: mag = QUARTER_SINE[6'(ph)];
			2'd1: mag = QUARTER_SINE[6'(127 - ph)];
			2'd2: mag = QUARTER_SINE[6'(ph - 128)];
			default: mag = QUARTER_SINE[6'(255 - ph)];
		endcase
		if (ph[7]) begin
			mag = 16'(0 - mag);
		end
		return mag;
	endfunction

	// Apply one accepted operation to the shadow state and queue its result words
	function automatic void advance_ring(input ring_op_t op);
		packer_out_t burst [$];
		packer_out_t r;
		logic [FILL_W-1:0] held;
		logic [15:0] v;
		int unsigned count, rate, target;
		held = wr_ptr - rd_ptr;
		r = '{status: STAT_PUSH_OK, word: '0, last: 1'b1, fill: '0};
		if (op.act == ACT_PUSH) begin
			if (held == '1) begin
				r.status = STAT_PUSH_FULL;
			end else begin
				ring_mem[wr_ptr] = {op.right, op.left};
				wr_ptr = wr_ptr + 1'b1;
			end
			burst.push_back(r);
		end else begin
			if (cfg_tone) begin
				count = TONE_PAIRS;
				rate = TONE_RATE;
			end else begin
				rate = cfg_rate;
				target = rate * 32 / 44100;
				if (target < 1) target = 1;
				if (target > MAX_PAIRS) target = MAX_PAIRS;
				count = (held < target) ? held : target;
			end
			if (!cfg_tone && count == 0) begin
				r.status = STAT_EMPTY;
				burst.push_back(r);
			end else if (op.dest < 8 + 4 * count) begin
				r.status = STAT_TOO_SMALL;
				burst.push_back(r);
			end else begin
				r.status = STAT_FRAME;
				r.last = 1'b0;
				r.word = cfg_magic;
				burst.push_back(r);
				r.word = {16'(rate), 16'(count)};
				burst.push_back(r);
				for (int k = 0; k < count; k++) begin
					if (cfg_tone) begin
						v = tone_value(phase_acc[31:24]);
						r.word = {v, v};
						phase_acc = phase_acc + TONE_STEP;
					end else begin
						r.word = ring_mem[rd_ptr];
						rd_ptr = rd_ptr + 1'b1;
					end
					r.last = (k == count - 1);
					burst.push_back(r);
				end
			end
		end
		held = wr_ptr - rd_ptr;
		foreach (burst[i]) begin
			burst[i].fill = held;
			owed_words.push_back(burst[i]);
		end
	endfunction

	function automatic ring_op_t push_op(input logic [15:0] left, input logic [15:0] right);
		return '{act: ACT_PUSH, dest: 16'($urandom), right: right, left: left};
	endfunction

	function automatic ring_op_t pack_op(input logic [DEST_W-1:0] dest);
		return '{act: ACT_PACK, dest: dest, right: 16'($urandom), left: 16'($urandom)};
	endfunction

	// Pushes at the given percentage, else frame requests, mostly well-sized with some short destinations
	function automatic ring_op_t rand_op(input int push_pct);
		logic [DEST_W-1:0] dest;
		if ($urandom_range(99) < push_pct) begin
			return push_op(16'($urandom), 16'($urandom));
		end
		case ($urandom_range(3))
			0: dest = 16'($urandom);
			1: dest = 16'($urandom_range(300));
			default: dest = 16'($urandom_range(65535, 196));
		endcase
		return pack_op(dest);
	endfunction

	// Write one register; the shadow copy follows immediately since the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		case (idx)
			REG_SMP_RATE: cfg_rate = data[RATE_W-1:0];
			REG_TONE_ENABLE: begin
				cfg_tone = data[0];
				phase_acc = '0;
			end
			REG_FRAME_MAGIC: cfg_magic = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Block until every queued operation is taken and every result has arrived
	task automatic wait_drained();
		do @(posedge clk);
		while (queued_ops.size() != 0 || s_axis_tvalid || owed_words.size() != 0);
	endtask

	// Offer the next queued operation once the previous transaction completed
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_took)) begin
			if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_op = queued_ops.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {next_op.dest, next_op.right, next_op.left};
				s_axis_tuser  <= next_op.act;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Randomly stall the output side, or hold it off entirely during a long hold
	always @(negedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	always begin
		@(long_hold_go);
		hold_off <= 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		hold_off <= 1'b0;
	end

	// Predict on each input transaction, check each output transaction
	always @(posedge clk) begin
		if (arst_n) begin
			s_took <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				seen_op = '{act: s_axis_tuser, dest: s_axis_tdata[47:32],
					right: s_axis_tdata[31:16], left: s_axis_tdata[15:0]};
				advance_ring(seen_op);
				n_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				n_out++;
				seen_status[m_axis_tuser]++;
				if (m_axis_tuser == STAT_FRAME && m_axis_tlast) n_frames++;
				if (owed_words.size() == 0) begin
					errors++;
					if (errors <= SHOWN_MAX)
						$display("%0t: unexpected result status %0d word %h", $realtime,
							m_axis_tuser, m_axis_tdata[31:0]);
				end else begin
					head_res = owed_words.pop_front();
					if (head_res.status != m_axis_tuser || head_res.word != m_axis_tdata[31:0] ||
							head_res.last != m_axis_tlast || head_res.fill != m_axis_tdata[41:32] ||
							m_axis_tdata[47:42] != '0) begin
						errors++;
						if (errors <= SHOWN_MAX)
							$display("%0t: mismatch exp st=%0d w=%h l=%b f=%0d got st=%0d w=%h l=%b f=%0d pad=%h",
								$realtime, head_res.status, head_res.word, head_res.last,
								head_res.fill, m_axis_tuser, m_axis_tdata[31:0], m_axis_tlast,
								m_axis_tdata[41:32], m_axis_tdata[47:42]);
					end
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Stimulus sequence: directed cases, output stall, random phases, rate steps
	initial begin
		int unsigned hi_rate;
		int unsigned step_k [3];
		step_k = '{2, 3, 47};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: empty ring, sample extremes, destination size boundary
		queued_ops.push_back(pack_op(16'hFFFF));
		queued_ops.push_back(push_op(16'h8000, 16'h7FFF));
		queued_ops.push_back(push_op(16'h7FFF, 16'h8000));
		queued_ops.push_back(push_op(16'h0000, 16'hFFFF));
		queued_ops.push_back(push_op(16'hFFFF, 16'h0000));
		queued_ops.push_back(pack_op(16'd0));
		queued_ops.push_back(pack_op(16'd23));
		queued_ops.push_back(pack_op(16'd24));
		wait_drained();

		// Zero rate clamps the frame to one pair; unknown register index is ignored
		write_reg(REG_FRAME_MAGIC, 32'hFFFF_FFFF);
		write_reg(REG_SMP_RATE, 32'd0);
		write_reg(REG_UNUSED, 32'hA5A5_5A5A);
		queued_ops.push_back(push_op(16'h1234, 16'hFEDC));
		queued_ops.push_back(push_op(16'h5555, 16'hAAAA));
		queued_ops.push_back(pack_op(16'd11));
		queued_ops.push_back(pack_op(16'd12));
		queued_ops.push_back(pack_op(16'd12));
		queued_ops.push_back(pack_op(16'hFFFF));
		wait_drained();

		// Test tone: too-small boundary, two frames, push still lands in the ring
		write_reg(REG_TONE_ENABLE, 32'd1);
		queued_ops.push_back(pack_op(16'd135));
		queued_ops.push_back(pack_op(16'd136));
		queued_ops.push_back(push_op(16'h0F0F, 16'hF0F0));
		queued_ops.push_back(pack_op(16'hFFFF));
		wait_drained();

		// Stall the input behind a long output hold, then drain the ring with frame requests
		write_reg(REG_TONE_ENABLE, 32'd0);
		write_reg(REG_SMP_RATE, 32'hFFFF);
		write_reg(REG_FRAME_MAGIC, $urandom);
		repeat (24) queued_ops.push_back(push_op(16'($urandom), 16'($urandom)));
		-> long_hold_go;
		repeat (2) queued_ops.push_back(pack_op(16'hFFFF));
		wait_drained();

		// Random traffic, normal frames at a random rate
		write_reg(REG_SMP_RATE, $urandom_range(65535));
		write_reg(REG_FRAME_MAGIC, $urandom);
		repeat (20) queued_ops.push_back(rand_op(60));
		wait_drained();

		// Random traffic in test-tone mode, idling swapped
		send_idle_pct = 74;
		recv_idle_pct = 29;
		write_reg(REG_TONE_ENABLE, 32'd1);
		write_reg(REG_FRAME_MAGIC, $urandom);
		repeat (20) queued_ops.push_back(rand_op(50));
		wait_drained();

		// Random traffic without idling, small rates favored
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_TONE_ENABLE, 32'd0);
		write_reg(REG_SMP_RATE, $urandom_range(8000));
		write_reg(REG_FRAME_MAGIC, 32'd0);
		repeat (20) queued_ops.push_back(rand_op(60));
		wait_drained();

		// Probe both sides of some frame-size steps of the rate division: at the step
		// the destination is one byte short, just below it the frame fits exactly
		repeat (50) queued_ops.push_back(push_op(16'($urandom), 16'($urandom)));
		wait_drained();
		foreach (step_k[i]) begin
			hi_rate = (step_k[i] * 11025 + 7) / 8;
			write_reg(REG_SMP_RATE, hi_rate);
			queued_ops.push_back(pack_op(16'(4 * step_k[i] + 7)));
			wait_drained();
			write_reg(REG_SMP_RATE, hi_rate - 1);
			queued_ops.push_back(pack_op(16'(4 * step_k[i] + 4)));
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (owed_words.size() != 0) begin
			errors++;
			$display("%0d expected results never arrived", owed_words.size());
		end
		$display("Covered %0d input and %0d output transactions, %0d frames", n_in, n_out, n_frames);
		$display("Refusals: %0d dropped pushes, %0d empty ring, %0d short destination",
			seen_status[STAT_PUSH_FULL], seen_status[STAT_EMPTY], seen_status[STAT_TOO_SMALL]);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/prfp_pkg.sv
rtl/pcm_ring_frame_packer.sv
tb/sv/tb.sv
